/* hw/rtl/i2cmbe_pkg.sv */
// i2cmbe_pkg: action codes, transfer payload types and constants for the i2c master bit engine
// no dependencies
`default_nettype none

package i2cmbe_pkg;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_START   = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_READ    = 3'd4,
    ACT_WAITACK = 3'd5,
    ACT_ACK     = 3'd6,
    ACT_NACK    = 3'd7
  } action_e;

  localparam logic [7:0] HalfPeriodReset = 8'd10;
  localparam logic [2:0] LastBit         = 3'd7;
  localparam int unsigned RegIdxHalf     = 0;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
    logic       rejected;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/i2c_master_bit_engine.sv */
// i2c_master_bit_engine: top level, bit sequencer with registered result and apb register
// depends on i2cmbe_pkg
`default_nettype none

// Bit-level I2C master. Every input transfer is a timer tick or a command (start, stop,
// write byte, read byte, wait ack, ack, nack); commands are taken only while idle and are
// otherwise flagged as rejected. Each delay between pin changes lasts half_period_ticks
// ticks (register at byte address 0, reset 10, 0 acts as 1). One item is accepted every
// clock cycle unless stalled; the output register shows its result in the next cycle;
// the input side stalls only while that register holds a result the output side stalls.
module i2c_master_bit_engine
  import i2cmbe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic       half_zero;
  logic [7:0] half_ticks_q;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  action_e    cmd_q, cmd_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_q, wait_d;
  logic       ack_q, ack_d;
  logic       in_accept;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, res;
  logic [7:0] load_val;
  logic       fin;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == 3'(RegIdxHalf * 4));
  assign prdata    = (paddr == 3'(RegIdxHalf * 4)) ? {24'd0, half_ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_ticks_q <= HalfPeriodReset;
    end else if (cfg_write) begin
      half_ticks_q <= pwdata[7:0];
    end
  end

  assign half_zero = (half_ticks_q == 8'd0);
  assign load_val  = half_zero ? 8'd1 : half_ticks_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    cmd_d   = cmd_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    ack_d   = ack_q;
    fin     = 1'b0;
    res     = '0;
    if (in_data_i.action != ACT_TICK) begin
      if (cmd_q != ACT_TICK) begin
        res.rejected = 1'b1;
      end else begin
        cmd_d   = in_data_i.action;
        phase_d = 2'd0;
        bit_d   = 3'd0;
        wait_d  = load_val;
        unique case (in_data_i.action)
          ACT_START: begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end
          ACT_STOP: begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end
          ACT_WRITE: begin
            shift_d = in_data_i.data_byte;
            sda_d   = in_data_i.data_byte[7];
          end
          ACT_READ: begin
            shift_d = 8'd0;
            scl_d   = 1'b1;
          end
          ACT_ACK: sda_d = 1'b0;
          default: sda_d = 1'b1;
        endcase
      end
    end else if (cmd_q != ACT_TICK) begin
      if (wait_q > 8'd1) begin
        wait_d = wait_q - 8'd1;
      end else begin
        wait_d = load_val;
        unique case (cmd_q)
          ACT_START: begin
            if (phase_q == 2'd0) begin
              sda_d   = 1'b0;
              phase_d = 2'd1;
            end else if (phase_q == 2'd1) begin
              scl_d   = 1'b0;
              phase_d = 2'd2;
            end else begin
              fin = 1'b1;
            end
          end
          ACT_STOP: begin
            sda_d = 1'b1;
            fin   = 1'b1;
          end
          ACT_WRITE: begin
            if (phase_q == 2'd0) begin
              scl_d   = 1'b1;
              phase_d = 2'd1;
            end else if (phase_q == 2'd1) begin
              scl_d   = 1'b0;
              if (bit_q == LastBit) sda_d = 1'b1;
              shift_d = {shift_q[6:0], 1'b0};
              phase_d = 2'd2;
            end else if (bit_q == LastBit) begin
              fin = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              sda_d   = shift_q[7];
              phase_d = 2'd0;
            end
          end
          ACT_READ: begin
            if (phase_q == 2'd0) begin
              shift_d = {shift_q[6:0], in_data_i.sda_in};
              scl_d   = 1'b0;
              phase_d = 2'd1;
            end else if (bit_q == LastBit) begin
              fin = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              scl_d   = 1'b1;
              phase_d = 2'd0;
            end
          end
          ACT_WAITACK: begin
            if (phase_q == 2'd0) begin
              scl_d   = 1'b1;
              phase_d = 2'd1;
            end else if (phase_q == 2'd1) begin
              ack_d   = in_data_i.sda_in;
              scl_d   = 1'b0;
              phase_d = 2'd2;
            end else begin
              fin = 1'b1;
            end
          end
          ACT_ACK, ACT_NACK: begin
            if (phase_q == 2'd0) begin
              scl_d   = 1'b1;
              phase_d = 2'd1;
            end else if (phase_q == 2'd1) begin
              scl_d   = 1'b0;
              phase_d = 2'd2;
            end else begin
              if (cmd_q == ACT_ACK) sda_d = 1'b1;
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          res.done_res = 1'b1;
          if (cmd_q == ACT_READ) res.read_data = shift_q;
          if (cmd_q == ACT_WAITACK) res.no_ack = ack_q;
          cmd_d   = ACT_TICK;
          phase_d = 2'd0;
          bit_d   = 3'd0;
          wait_d  = 8'd0;
        end
      end
    end
    res.scl_level = scl_d;
    res.sda_level = sda_d;
    res.busy_res  = (cmd_d != ACT_TICK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      cmd_q   <= ACT_TICK;
      phase_q <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      wait_q  <= 8'd0;
      ack_q   <= 1'b0;
    end else if (in_accept) begin
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      ack_q   <= ack_d;
    end
  end

  assign out_valid_d = in_accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == ACT_TICK) == (wait_q == 8'd0))
    else $error("delay counter out of step with command state");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res && !out_q.rejected)
    else $error("done result still busy or rejected");

  a_cmd_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.action != ACT_TICK) && (cmd_q == ACT_TICK)
    |=> (cmd_q != ACT_TICK) && out_valid_q && !out_q.rejected)
    else $error("command taken while idle did not start");

endmodule

`default_nettype wire
